>>> rtl/core/tvs_pkg.sv
package tvs_pkg;

    localparam int HOUR_W = 5;
    localparam int MIN_W  = 6;
    localparam int SLOT_W = 4;
    localparam int MASK_W = 16;
    localparam int DUR_W  = 8;
    localparam int NEXT_W = 5;
    localparam int PEV_W  = 2;

    localparam int APB_AW = 4;
    localparam int APB_DW = 32;

    localparam logic FUNC_TICK  = 1'b0;
    localparam logic FUNC_WRITE = 1'b1;

    localparam logic [PEV_W-1:0] PUMP_NONE = 2'd0;
    localparam logic [PEV_W-1:0] PUMP_ON   = 2'd1;
    localparam logic [PEV_W-1:0] PUMP_OFF  = 2'd2;

    localparam logic [1:0] REG_START_HOUR    = 2'd0;
    localparam logic [1:0] REG_START_MINUTE  = 2'd1;
    localparam logic [1:0] REG_WAIT_FOR_PUMP = 2'd2;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_WAIT,
        PH_ACTIVE
    } phase_t;

    typedef struct packed {
        logic              func;
        logic [HOUR_W-1:0] hour;
        logic [MIN_W-1:0]  minute;
        logic              pump_ready;
        logic [SLOT_W-1:0] entry_index;
        logic [MASK_W-1:0] entry_valves;
        logic [DUR_W-1:0]  entry_duration;
        logic              entry_valid;
    } in_item_t;

    typedef struct packed {
        logic [PEV_W-1:0]  pump_event;
        logic              valve_event;
        logic [MASK_W-1:0] valve_mask;
        logic              running;
        logic              pump_is_ready;
        logic [SLOT_W-1:0] step_number;
        logic [DUR_W-1:0]  time_left;
        logic [DUR_W-1:0]  step_duration;
    } out_item_t;

    typedef struct packed {
        logic [MASK_W-1:0] valves;
        logic [DUR_W-1:0]  duration;
    } entry_t;

    typedef struct packed {
        logic [HOUR_W-1:0] start_hour;
        logic [MIN_W-1:0]  start_minute;
        logic              wait_for_pump;
    } cfg_t;

    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] index;
        entry_t            data;
        logic              valid;
    } tbl_wr_t;

    typedef struct packed {
        logic              en;
        logic [NEXT_W-1:0] slot;
    } tbl_rd_t;

endpackage

>>> rtl/core/tvs_if.sv
interface tvs_in_if import tvs_pkg::*; ();
    logic     valid;
    logic     ready;
    in_item_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface tvs_out_if import tvs_pkg::*; ();
    logic      valid;
    logic      ready;
    out_item_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

>>> rtl/core/tvs_cfg.sv
module tvs_cfg import tvs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output cfg_t              cfg
);

    logic [HOUR_W-1:0] start_hour_reg;
    logic [MIN_W-1:0]  start_minute_reg;
    logic              wait_for_pump_reg;
    logic [1:0]        reg_sel;
    logic              wr_en;

    assign reg_sel = paddr[3:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_hour_reg    <= '0;
            start_minute_reg  <= '0;
            wait_for_pump_reg <= 1'b1;
        end
        else if (wr_en)
        begin
            unique case (reg_sel)
                REG_START_HOUR:    start_hour_reg    <= pwdata[HOUR_W-1:0];
                REG_START_MINUTE:  start_minute_reg  <= pwdata[MIN_W-1:0];
                REG_WAIT_FOR_PUMP: wait_for_pump_reg <= pwdata[0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            REG_START_HOUR:    prdata = APB_DW'(start_hour_reg);
            REG_START_MINUTE:  prdata = APB_DW'(start_minute_reg);
            REG_WAIT_FOR_PUMP: prdata = APB_DW'(wait_for_pump_reg);
            default:           prdata = '0;
        endcase
    end

    assign cfg.start_hour    = start_hour_reg;
    assign cfg.start_minute  = start_minute_reg;
    assign cfg.wait_for_pump = wait_for_pump_reg;

endmodule

>>> rtl/core/tvs_table.sv
module tvs_table import tvs_pkg::*;
#(
    parameter int TABLE_DEPTH = 16
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  tbl_wr_t           wr,
    input  tbl_rd_t           rd,
    output entry_t            rd_data,
    input  logic [NEXT_W-1:0] chk_slot,
    output logic              chk_valid
);

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam logic [NEXT_W:0] DEPTH_LIM = (NEXT_W+1)'(TABLE_DEPTH);

    entry_t                 mem [TABLE_DEPTH];
    entry_t                 rd_data_reg;
    logic [TABLE_DEPTH-1:0] valid_reg;
    logic [TABLE_DEPTH-1:0] valid_next;
    logic [NEXT_W:0]        wr_ext;
    logic                   wr_hit;
    logic [IDX_W-1:0]       wr_idx;
    logic [IDX_W-1:0]       rd_idx;
    logic [IDX_W-1:0]       chk_idx;
    logic                   chk_in_range;

    assign wr_ext       = (NEXT_W+1)'(wr.index);
    assign wr_hit       = wr.en && (wr_ext < DEPTH_LIM);
    assign wr_idx       = wr_ext[IDX_W-1:0];
    assign rd_idx       = rd.slot[IDX_W-1:0];
    assign chk_idx      = chk_slot[IDX_W-1:0];
    assign chk_in_range = {1'b0, chk_slot} < DEPTH_LIM;

    always_ff @(posedge clk)
    begin
        if (wr_hit)
        begin
            mem[wr_idx] <= wr.data;
        end
        if (rd.en)
        begin
            rd_data_reg <= mem[rd_idx];
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (wr_hit)
        begin
            valid_next[wr_idx] = wr.valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign rd_data   = rd_data_reg;
    assign chk_valid = chk_in_range ? valid_reg[chk_idx] : 1'b0;

endmodule

>>> rtl/core/tvs_engine.sv
module tvs_engine import tvs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  cfg_t              cfg,
    input  logic              in_valid,
    output logic              in_ready,
    input  in_item_t          in_item,
    output logic              out_valid,
    input  logic              out_ready,
    output out_item_t         out_item,
    output tbl_wr_t           tbl_wr,
    output tbl_rd_t           tbl_rd,
    input  entry_t            tbl_data,
    output logic [NEXT_W-1:0] chk_slot,
    input  logic              chk_valid
);

    logic              s1_valid_reg;
    in_item_t          s1_item_reg;
    logic              out_valid_reg;
    out_item_t         out_item_reg;

    phase_t            phase_reg,           phase_next;
    logic [NEXT_W-1:0] next_slot_reg,       next_slot_next;
    logic [DUR_W-1:0]  countdown_reg,       countdown_next;
    logic              ready_latch_reg,     ready_latch_next;
    logic [SLOT_W-1:0] active_slot_reg,     active_slot_next;
    logic [MASK_W-1:0] active_valves_reg,   active_valves_next;
    logic [DUR_W-1:0]  active_duration_reg, active_duration_next;

    logic              advance;
    logic              accept;
    logic              fire;
    logic              go;
    logic              act;
    logic [PEV_W-1:0]  pev;
    logic              vev;
    out_item_t         result;

    assign advance  = !out_valid_reg || out_ready;
    assign in_ready = !s1_valid_reg || advance;
    assign accept   = in_valid && in_ready;
    assign fire     = s1_valid_reg && advance;
    assign chk_slot = next_slot_reg;

    always_comb
    begin
        phase_next           = phase_reg;
        next_slot_next       = next_slot_reg;
        countdown_next       = countdown_reg;
        ready_latch_next     = ready_latch_reg;
        active_slot_next     = active_slot_reg;
        active_valves_next   = active_valves_reg;
        active_duration_next = active_duration_reg;
        pev                  = PUMP_NONE;
        vev                  = 1'b0;
        go                   = fire && (s1_item_reg.func == FUNC_TICK);

        if (go && (phase_reg == PH_IDLE))
        begin
            if ((s1_item_reg.hour != cfg.start_hour) ||
                (s1_item_reg.minute != cfg.start_minute))
            begin
                go = 1'b0;
            end
            else
            begin
                phase_next     = PH_WAIT;
                next_slot_next = '0;
                pev            = PUMP_ON;
            end
        end

        if (go)
        begin
            priority if (!ready_latch_reg && cfg.wait_for_pump)
            begin
                ready_latch_next = s1_item_reg.pump_ready;
            end
            else if (countdown_reg != '0)
            begin
                countdown_next = countdown_reg - DUR_W'(1);
            end
            else if (!chk_valid)
            begin
                phase_next           = PH_IDLE;
                ready_latch_next     = 1'b0;
                active_slot_next     = '0;
                active_valves_next   = '0;
                active_duration_next = '0;
                countdown_next       = '0;
                next_slot_next       = '0;
                pev                  = PUMP_OFF;
            end
            else
            begin
                active_slot_next     = next_slot_reg[SLOT_W-1:0];
                active_valves_next   = tbl_data.valves;
                active_duration_next = tbl_data.duration;
                countdown_next       = tbl_data.duration;
                phase_next           = PH_ACTIVE;
                next_slot_next       = next_slot_reg + NEXT_W'(1);
                vev                  = 1'b1;
            end
        end

        act                  = (phase_next == PH_ACTIVE);
        result.pump_event    = pev;
        result.valve_event   = vev;
        result.valve_mask    = act ? active_valves_next : '0;
        result.running       = act;
        result.pump_is_ready = ready_latch_next;
        result.step_number   = act ? active_slot_next : '0;
        result.time_left     = countdown_next;
        result.step_duration = act ? active_duration_next : '0;
    end

    // The read address already reflects the slot the item ahead of it leaves behind.
    assign tbl_rd.en   = accept && (in_item.func == FUNC_TICK);
    assign tbl_rd.slot = fire ? next_slot_next : next_slot_reg;

    assign tbl_wr.en            = accept && (in_item.func == FUNC_WRITE);
    assign tbl_wr.index         = in_item.entry_index;
    assign tbl_wr.data.valves   = in_item.entry_valves;
    assign tbl_wr.data.duration = in_item.entry_duration;
    assign tbl_wr.valid         = in_item.entry_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg        <= 1'b0;
            out_valid_reg       <= 1'b0;
            phase_reg           <= PH_IDLE;
            next_slot_reg       <= '0;
            countdown_reg       <= '0;
            ready_latch_reg     <= 1'b0;
            active_slot_reg     <= '0;
            active_valves_reg   <= '0;
            active_duration_reg <= '0;
        end
        else
        begin
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (fire)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (fire)
            begin
                phase_reg           <= phase_next;
                next_slot_reg       <= next_slot_next;
                countdown_reg       <= countdown_next;
                ready_latch_reg     <= ready_latch_next;
                active_slot_reg     <= active_slot_next;
                active_valves_reg   <= active_valves_next;
                active_duration_reg <= active_duration_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_item_reg <= in_item;
        end
        if (fire)
        begin
            out_item_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

>>> rtl/core/timed_valve_sequencer.sv
// An accepted beat is held in the input stage register until the output can take it;
// then the state and output registers load. Throughput: one input beat per cycle
// unless the output stalls, with the table read issued in the accept cycle.
// Reset clears the run state, marks every table slot empty and sets the start time
// to 00:00 with pump polling enabled; no clearing pass is needed.
module timed_valve_sequencer import tvs_pkg::*;
#(
    parameter int TABLE_DEPTH = 16
)
(
    input  logic              clk,
    input  logic              rst_n,
    tvs_in_if.sink            in_ch,
    tvs_out_if.source         out_ch,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    cfg_t              cfg;
    tbl_wr_t           tbl_wr;
    tbl_rd_t           tbl_rd;
    entry_t            tbl_data;
    logic [NEXT_W-1:0] chk_slot;
    logic              chk_valid;

    tvs_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    tvs_table #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr        (tbl_wr),
        .rd        (tbl_rd),
        .rd_data   (tbl_data),
        .chk_slot  (chk_slot),
        .chk_valid (chk_valid)
    );

    tvs_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .in_item   (in_ch.payload),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .out_item  (out_ch.payload),
        .tbl_wr    (tbl_wr),
        .tbl_rd    (tbl_rd),
        .tbl_data  (tbl_data),
        .chk_slot  (chk_slot),
        .chk_valid (chk_valid)
    );

endmodule

>>> rtl/core/tvs_checker.sv
module tvs_assertions import tvs_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    tvs_out_if.source out_ch
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.payload))
        else $error("result beat changed while stalled");

    a_idle_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && !out_ch.payload.running |->
            out_ch.payload.valve_mask == '0 && out_ch.payload.step_number == '0 &&
            out_ch.payload.step_duration == '0)
        else $error("entry fields reported without an active entry");

    a_valve_load: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.payload.valve_event |->
            out_ch.payload.running &&
            out_ch.payload.time_left == out_ch.payload.step_duration)
        else $error("new valve mask without a freshly loaded entry");

    a_pump_off: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.payload.pump_event == PUMP_OFF |->
            !out_ch.payload.running && !out_ch.payload.pump_is_ready &&
            out_ch.payload.time_left == '0 && !out_ch.payload.valve_event)
        else $error("pump off without a cleared run state");

endmodule

bind timed_valve_sequencer tvs_assertions u_tvs_assertions (
    .clk    (clk),
    .rst_n  (rst_n),
    .out_ch (out_ch)
);
